/* hdl/assert_macros.svh */
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define ASSERT_CLKD(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed: port behavior violated");

// Checked at every rising edge, reset included.
`define ASSERT_ANY(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed: reset behavior violated");

`endif

/* hdl/dfr_pkg.sv */
// Package with shared codes, widths and the texel permutation of the flip/rotate block.
`default_nettype none

package dfr_pkg;

    localparam int HalfW  = 64;
    localparam int DimW   = 15;
    localparam int CfgW   = 2;
    localparam int CfgIdxW = 1;
    localparam int InDataW  = 160;
    localparam int OutDataW = 128;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_BLOCK_FORMAT   = 1'b0;
    localparam logic [CfgIdxW-1:0] REG_TRANSFORM_MODE = 1'b1;

    // Block format codes.
    localparam logic [CfgW-1:0] FMT_DXT1 = 2'd0;
    localparam logic [CfgW-1:0] FMT_DXT3 = 2'd1;
    localparam logic [CfgW-1:0] FMT_DXT5 = 2'd2;

    // Transform codes.
    localparam logic [CfgW-1:0] XF_HFLIP  = 2'd0;
    localparam logic [CfgW-1:0] XF_VFLIP  = 2'd1;
    localparam logic [CfgW-1:0] XF_ROTATE = 2'd2;

    typedef logic [HalfW-1:0] half_t;
    typedef logic [DimW-1:0]  dim_t;
    typedef logic [CfgW-1:0]  cfg_t;

    // Which texel permutation one block gets.
    typedef enum logic [3:0] {
        PERM_IDENT,
        PERM_HFULL,
        PERM_HHALF,
        PERM_VFULL,
        PERM_VHALF,
        PERM_R21,
        PERM_R41,
        PERM_R12,
        PERM_R22,
        PERM_RFULL
    } perm_kind_t;

    // Source texel for destination texel i, with texel index 4*y + x.
    function automatic logic [3:0] perm_src(input perm_kind_t kind, input logic [3:0] i);
        logic [1:0] x;
        logic [1:0] y;
        logic [3:0] s;
        x = i[1:0];
        y = i[3:2];
        s = i;
        case (kind)
            PERM_HFULL: s = {y, ~x};
            PERM_HHALF: s = x[1] ? i : {y, 1'b0, ~x[0]};
            PERM_VFULL: s = {~y, x};
            PERM_VHALF: s = y[1] ? i : {1'b0, ~y[0], x};
            PERM_RFULL: s = {~x, y};
            PERM_R21:   s = (i == 4'd4) ? 4'd1 : i;
            PERM_R41: begin
                case (i)
                    4'd4:    s = 4'd1;
                    4'd8:    s = 4'd2;
                    4'd12:   s = 4'd3;
                    default: s = i;
                endcase
            end
            PERM_R12:   s = (i == 4'd1) ? 4'd4 : i;
            PERM_R22: begin
                case (i)
                    4'd0:    s = 4'd4;
                    4'd4:    s = 4'd5;
                    4'd5:    s = 4'd1;
                    4'd1:    s = 4'd0;
                    4'd8:    s = 4'd6;
                    4'd12:   s = 4'd7;
                    4'd13:   s = 4'd3;
                    4'd9:    s = 4'd2;
                    default: s = i;
                endcase
            end
            default:    s = i;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* hdl/dxt_block_flip_rotate.sv */
// Requests pass the input register, then the result register, to the master side.
// Throughput: one block per cycle while the result is not stalled; the input register
// feeds the permutation logic, whose output lands in the result register.
// A stalled result still lets one more request into the input register.
// Reset (aresetn low, synchronous) empties both stages and clears the format and
// transform registers to DXT1 and horizontal flip.
`default_nettype none

module dxt_block_flip_rotate (
    input  wire                               aclk,
    input  wire                               aresetn,
    // Input requests.
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire [dfr_pkg::InDataW-1:0]        s_tdata,  // alpha_half, colour_half,
                                                        // level_width, level_height, 2 pad
    // Results.
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [dfr_pkg::OutDataW-1:0]      m_tdata,  // alpha_half_out, colour_half_out
    // Configuration writes.
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [dfr_pkg::CfgIdxW-1:0]        cfg_index,
    input  wire [dfr_pkg::CfgW-1:0]           cfg_data
);
    import dfr_pkg::*;

    cfg_t  fmt_reg;
    cfg_t  mode_reg;
    logic  s1_valid_reg;
    half_t s1_alpha_reg;
    half_t s1_colour_reg;
    dim_t  s1_width_reg;
    dim_t  s1_height_reg;
    logic  m_valid_reg;
    logic [OutDataW-1:0] m_data_reg;
    half_t alpha_perm;
    half_t colour_perm;
    logic  s1_load;
    logic  m_load;

    // Configuration registers are always writable.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg  <= FMT_DXT1;
            mode_reg <= XF_HFLIP;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_BLOCK_FORMAT:   fmt_reg  <= cfg_data;
                REG_TRANSFORM_MODE: mode_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Each stage advances when it is empty or the stage after it takes its request.
    assign m_load   = !m_valid_reg || m_tready;
    assign s1_load  = !s1_valid_reg || m_load;
    assign s_tready = s1_load;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_load) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load && s_tvalid) begin
            s1_alpha_reg  <= s_tdata[HalfW-1:0];
            s1_colour_reg <= s_tdata[2*HalfW-1:HalfW];
            s1_width_reg  <= s_tdata[2*HalfW+DimW-1:2*HalfW];
            s1_height_reg <= s_tdata[2*HalfW+2*DimW-1:2*HalfW+DimW];
        end
    end

    dfr_perm u_perm (
        .block_format    (fmt_reg),
        .transform_mode  (mode_reg),
        .alpha_half      (s1_alpha_reg),
        .colour_half     (s1_colour_reg),
        .level_width     (s1_width_reg),
        .level_height    (s1_height_reg),
        .alpha_half_out  (alpha_perm),
        .colour_half_out (colour_perm)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_load) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_load && s1_valid_reg) begin
            m_data_reg <= {colour_perm, alpha_perm};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

/* hdl/dfr_perm.sv */
// Combinational index permutation for one DXT block: picks the permutation and applies it.
`default_nettype none

module dfr_perm (
    input  wire dfr_pkg::cfg_t  block_format,
    input  wire dfr_pkg::cfg_t  transform_mode,
    input  wire dfr_pkg::half_t alpha_half,
    input  wire dfr_pkg::half_t colour_half,
    input  wire dfr_pkg::dim_t  level_width,
    input  wire dfr_pkg::dim_t  level_height,
    output dfr_pkg::half_t      alpha_half_out,
    output dfr_pkg::half_t      colour_half_out
);
    import dfr_pkg::*;

    perm_kind_t kind;
    half_t      alpha_dxt3;
    half_t      alpha_dxt5;
    half_t      colour_perm;

    // Select the permutation from the transform and the level size.
    always_comb begin
        kind = PERM_IDENT;
        unique case (transform_mode)
            XF_HFLIP: begin
                if (level_width == 15'd1)      kind = PERM_IDENT;
                else if (level_width == 15'd2) kind = PERM_HHALF;
                else                           kind = PERM_HFULL;
            end
            XF_VFLIP: begin
                if (level_height == 15'd1)      kind = PERM_IDENT;
                else if (level_height == 15'd2) kind = PERM_VHALF;
                else                            kind = PERM_VFULL;
            end
            XF_ROTATE: begin
                // Rotated width is the level height and rotated height the level width.
                if (level_width == 15'd1 && level_height == 15'd1)
                    kind = PERM_IDENT;
                else if (level_height == 15'd2 && level_width == 15'd1)
                    kind = PERM_R21;
                else if (level_height == 15'd4 && level_width == 15'd1)
                    kind = PERM_R41;
                else if (level_height == 15'd1 && level_width == 15'd2)
                    kind = PERM_R12;
                else if ((level_height == 15'd2 || level_height == 15'd4)
                         && level_width == 15'd2)
                    kind = PERM_R22;
                else
                    kind = PERM_RFULL;
            end
            default: kind = PERM_IDENT;
        endcase
    end

    // Move every index plane texel by texel; endpoints and headers stay in place.
    always_comb begin
        logic [3:0] src;
        alpha_dxt3  = alpha_half;
        alpha_dxt5  = alpha_half;
        colour_perm = colour_half;
        for (int i = 0; i < 16; i++) begin
            src = perm_src(kind, 4'(i));
            alpha_dxt3[4*i +: 4]       = alpha_half[4*src +: 4];
            alpha_dxt5[16 + 3*i +: 3]  = alpha_half[16 + 3*src +: 3];
            colour_perm[32 + 2*i +: 2] = colour_half[32 + 2*src +: 2];
        end
    end

    // The alpha plane depends on the block format.
    always_comb begin
        unique case (block_format)
            FMT_DXT3: alpha_half_out = alpha_dxt3;
            FMT_DXT5: alpha_half_out = alpha_dxt5;
            default:  alpha_half_out = alpha_half;
        endcase
    end

    assign colour_half_out = colour_perm;

endmodule

`default_nettype wire

/* hdl/dfr_checker.sv */
// Port-level checker for the flip/rotate block and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module dfr_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          s_tvalid,
    input wire                          s_tready,
    input wire                          m_tvalid,
    input wire                          m_tready,
    input wire [dfr_pkg::OutDataW-1:0]  m_tdata,
    input wire                          cfg_valid,
    input wire                          cfg_ready
);
    import dfr_pkg::*;

    logic unused_in;
    assign unused_in = s_tvalid ^ cfg_valid;

    // A stalled result stays valid and unchanged.
    `ASSERT_CLKD(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    // Input is held back only while a result is waiting on the output side.
    `ASSERT_CLKD(a_ready_backpressure, aclk, aresetn, !s_tready |-> m_tvalid && !m_tready)
    // Configuration writes are never refused.
    `ASSERT_CLKD(a_cfg_ready, aclk, aresetn, cfg_ready)
    // Reset leaves no result pending.
    `ASSERT_ANY(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

endmodule

bind dxt_block_flip_rotate dfr_checker u_dfr_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

/* test/dxt_block_flip_rotate_test.sv */
// Self-checking testbench for the DXT block flip/rotate unit: randomized stream with a scoreboard.
`default_nettype none

module dxt_block_flip_rotate_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dfr_pkg::*;

    localparam int   LatencyCycles   = 2;
    localparam int   BlocksPerPhase  = 80;
    localparam int   SinkHoldCycles  = 60;
    localparam int   PressurePhase   = 5;
    localparam int   PressureStart   = 20;
    localparam int   PressureEnd     = 40;
    localparam real  TimeoutNs       = 10_000_000.0;

    // Spare register codes: format 3 behaves as DXT1, transform 3 passes blocks through.
    localparam cfg_t FMT_SPARE = 2'd3;
    localparam cfg_t XF_SPARE  = 2'd3;

    // Source texel for each destination texel, texel index 4*y + x.
    typedef logic [15:0][3:0] texel_map_t;

    typedef struct packed {
        half_t alpha;
        half_t colour;
    } dxt_block_t;

    // Tracks the register copy, predicts each request and checks the results in order.
    class flip_rotate_scoreboard;
        cfg_t       block_format;
        cfg_t       transform_mode;
        dxt_block_t expected_blocks[$];
        int         mismatches;
        int         checked;

        function new();
            block_format   = FMT_DXT1;
            transform_mode = XF_HFLIP;
            mismatches     = 0;
            checked        = 0;
        endfunction

        function void note_register(logic [CfgIdxW-1:0] index, cfg_t value);
            if (index == REG_BLOCK_FORMAT) begin
                block_format = value;
            end else begin
                transform_mode = value;
            end
        endfunction

        // Returns 0 when the block passes through untouched.
        function bit texel_sources(dim_t w, dim_t h, output texel_map_t src);
            int   i;
            int   x;
            int   y;
            int   sx;
            int   sy;
            int   s;
            dim_t rot_w;
            dim_t rot_h;
            for (i = 0; i < 16; i++) begin
                src[i] = i[3:0];
            end
            if (transform_mode == XF_HFLIP) begin
                if (w == 1) return 1'b0;
                for (i = 0; i < 16; i++) begin
                    x = i % 4;
                    y = i / 4;
                    // Width 2 only swaps the two used columns.
                    if (w == 2) sx = (x < 2) ? 1 - x : x;
                    else        sx = 3 - x;
                    s = 4 * y + sx;
                    src[i] = s[3:0];
                end
                return 1'b1;
            end
            if (transform_mode == XF_VFLIP) begin
                if (h == 1) return 1'b0;
                for (i = 0; i < 16; i++) begin
                    x = i % 4;
                    y = i / 4;
                    if (h == 2) sy = (y < 2) ? 1 - y : y;
                    else        sy = 3 - y;
                    s = 4 * sy + x;
                    src[i] = s[3:0];
                end
                return 1'b1;
            end
            if (transform_mode == XF_ROTATE) begin
                if (w == 1 && h == 1) return 1'b0;
                // Small levels are classified by their size after the turn.
                rot_w = h;
                rot_h = w;
                if (rot_w == 2 && rot_h == 1) begin
                    src[4] = 4'd1;
                end else if (rot_w == 4 && rot_h == 1) begin
                    src[4]  = 4'd1;
                    src[8]  = 4'd2;
                    src[12] = 4'd3;
                end else if (rot_w == 1 && rot_h == 2) begin
                    src[1] = 4'd4;
                end else if ((rot_w == 2 || rot_w == 4) && rot_h == 2) begin
                    src[0]  = 4'd4;
                    src[4]  = 4'd5;
                    src[5]  = 4'd1;
                    src[1]  = 4'd0;
                    src[8]  = 4'd6;
                    src[12] = 4'd7;
                    src[13] = 4'd3;
                    src[9]  = 4'd2;
                end else begin
                    for (i = 0; i < 16; i++) begin
                        x = i % 4;
                        y = i / 4;
                        s = 12 - 4 * x + y;
                        src[i] = s[3:0];
                    end
                end
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Moves each texel's index field of one plane to its new place.
        function half_t permute_plane(half_t word, int base, int bits, texel_map_t src);
            half_t result;
            int    i;
            int    b;
            int    from;
            result = word;
            for (i = 0; i < 16; i++) begin
                from = src[i];
                for (b = 0; b < bits; b++) begin
                    result[base + bits * i + b] = word[base + bits * from + b];
                end
            end
            return result;
        endfunction

        function void note_request(logic [InDataW-1:0] data);
            dxt_block_t blk;
            texel_map_t src;
            dim_t       w;
            dim_t       h;
            blk.alpha  = data[0 +: HalfW];
            blk.colour = data[HalfW +: HalfW];
            w          = data[2 * HalfW +: DimW];
            h          = data[2 * HalfW + DimW +: DimW];
            if (texel_sources(w, h, src)) begin
                if (block_format == FMT_DXT3) begin
                    blk.alpha = permute_plane(blk.alpha, 0, 4, src);
                end else if (block_format == FMT_DXT5) begin
                    blk.alpha = permute_plane(blk.alpha, 16, 3, src);
                end
                blk.colour = permute_plane(blk.colour, 32, 2, src);
            end
            expected_blocks.push_back(blk);
        endfunction

        function void check_result(logic [OutDataW-1:0] data);
            dxt_block_t want;
            half_t      alpha;
            half_t      colour;
            alpha  = data[0 +: HalfW];
            colour = data[HalfW +: HalfW];
            if (expected_blocks.size() == 0) begin
                $display("%0t: unexpected result alpha %h colour %h", $time, alpha, colour);
                mismatches++;
                return;
            end
            want = expected_blocks.pop_front();
            checked++;
            if (alpha !== want.alpha) begin
                $display("%0t: alpha half expected %h, actual %h", $time, want.alpha, alpha);
                mismatches++;
            end
            if (colour !== want.colour) begin
                $display("%0t: colour half expected %h, actual %h", $time, want.colour, colour);
                mismatches++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [InDataW-1:0]    s_tdata;   // alpha_half, colour_half, level_width, level_height, pad
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OutDataW-1:0]   m_tdata;   // alpha_half_out, colour_half_out
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CfgIdxW-1:0]    cfg_index;
    cfg_t                  cfg_data;

    flip_rotate_scoreboard scoreboard = new();

    int   source_gap_pct;
    int   sink_stall_pct;
    bit   sink_hold_req;
    int   blocks_sent;
    cfg_t format_codes [4];
    cfg_t transform_codes [4];

    dxt_block_flip_rotate u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Mostly short gaps, now and then a long one.
    function automatic int idle_length(int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic half_t random_half();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return '0;
        if (pick == 1) return {HalfW{1'b1}};
        return {$urandom, $urandom};
    endfunction

    // Favors the small levels where the reduced permutations live.
    function automatic dim_t random_dim();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return dim_t'($urandom_range(1, 4));
        if (pick < 65) return dim_t'(16384);
        return dim_t'($urandom_range(1, 16384));
    endfunction

    // Offers one request after any idle gap and returns once it is taken.
    task automatic send_block(input half_t alpha, input half_t colour, input dim_t w,
                              input dim_t h, input int gap);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, h, w, colour, alpha};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        blocks_sent++;
    endtask

    task automatic program_register(input logic [CfgIdxW-1:0] index, input cfg_t value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stops offering requests and waits until the pipeline is empty.
    task automatic drain_requests();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (scoreboard.expected_blocks.size() != 0) @(posedge aclk);
        repeat (LatencyCycles + 2) @(posedge aclk);
    endtask

    // Result side: random back-pressure plus one long hold-off on request.
    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold_req) begin
                m_tready <= 1'b0;
                repeat (SinkHoldCycles - 1) @(negedge aclk);
                sink_hold_req = 1'b0;
            end else begin
                stall = idle_length(sink_stall_pct);
                if (stall == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    repeat (stall - 1) @(negedge aclk);
                end
            end
        end
    end

    // Every handshake is observed here, on the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) scoreboard.check_result(m_tdata);
            if (s_tvalid && s_tready) scoreboard.note_request(s_tdata);
            if (cfg_valid && cfg_ready) scoreboard.note_register(cfg_index, cfg_data);
        end
    end

    initial begin
        #(TimeoutNs);
        $display("Timeout with %0d results outstanding", scoreboard.expected_blocks.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int f;
        int m;
        int phase;
        int n;
        int gap;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_BLOCK_FORMAT;
        cfg_data       = FMT_DXT1;
        sink_hold_req  = 1'b0;
        source_gap_pct = 30;
        sink_stall_pct = 30;
        blocks_sent    = 0;
        format_codes    = '{FMT_DXT1, FMT_DXT3, FMT_DXT5, FMT_SPARE};
        transform_codes = '{XF_HFLIP, XF_VFLIP, XF_ROTATE, XF_SPARE};

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Rotation over every reduced size, the 1x1 pass-through and full quarter turns.
        program_register(REG_BLOCK_FORMAT, FMT_DXT5);
        program_register(REG_TRANSFORM_MODE, XF_ROTATE);
        send_block({HalfW{1'b1}}, {HalfW{1'b1}}, 1, 1, 0);
        send_block('0, '0, 1, 2, 0);
        send_block(random_half(), random_half(), 1, 4, idle_length(source_gap_pct));
        send_block(random_half(), random_half(), 2, 1, idle_length(source_gap_pct));
        send_block(random_half(), random_half(), 2, 2, idle_length(source_gap_pct));
        send_block(random_half(), random_half(), 2, 4, idle_length(source_gap_pct));
        send_block(random_half(), random_half(), 3, 3, idle_length(source_gap_pct));
        send_block(random_half(), random_half(), 2, 3, idle_length(source_gap_pct));
        send_block(random_half(), random_half(), 1, 3, idle_length(source_gap_pct));
        send_block({HalfW{1'b1}}, random_half(), 16384, 16384, 0);
        drain_requests();

        // Horizontal flip with DXT3 alphas: width 1, width 2 and full mirrors.
        program_register(REG_BLOCK_FORMAT, FMT_DXT3);
        program_register(REG_TRANSFORM_MODE, XF_HFLIP);
        send_block(random_half(), random_half(), 1, 4, 0);
        send_block(random_half(), random_half(), 2, 4, 0);
        send_block(random_half(), random_half(), 3, 1, 0);
        send_block(random_half(), random_half(), 16384, 2, 0);
        drain_requests();

        // Vertical flip with DXT1: height 1, height 2 and full mirrors.
        program_register(REG_BLOCK_FORMAT, FMT_DXT1);
        program_register(REG_TRANSFORM_MODE, XF_VFLIP);
        send_block(random_half(), random_half(), 4, 1, 0);
        send_block(random_half(), random_half(), 4, 2, 0);
        send_block(random_half(), random_half(), 1, 4, 0);
        send_block(random_half(), random_half(), 2, 16384, 0);
        drain_requests();

        // Spare codes: format 3 keeps alpha, transform 3 keeps the whole block.
        program_register(REG_BLOCK_FORMAT, FMT_SPARE);
        program_register(REG_TRANSFORM_MODE, XF_ROTATE);
        send_block(random_half(), random_half(), 4, 4, 0);
        drain_requests();
        program_register(REG_BLOCK_FORMAT, FMT_DXT5);
        program_register(REG_TRANSFORM_MODE, XF_SPARE);
        send_block(random_half(), random_half(), 4, 4, 0);
        drain_requests();

        // Random blocks under every format and transform pairing.
        phase = 0;
        for (f = 0; f < 4; f++) begin
            for (m = 0; m < 4; m++) begin
                program_register(REG_BLOCK_FORMAT, format_codes[f]);
                program_register(REG_TRANSFORM_MODE, transform_codes[m]);
                case (phase % 4)
                    0: begin
                        source_gap_pct = 0;
                        sink_stall_pct = 0;
                    end
                    1: begin
                        source_gap_pct = 25;
                        sink_stall_pct = 10;
                    end
                    2: begin
                        source_gap_pct = 10;
                        sink_stall_pct = 40;
                    end
                    default: begin
                        source_gap_pct = 50;
                        sink_stall_pct = 50;
                    end
                endcase
                for (n = 0; n < BlocksPerPhase; n++) begin
                    // One phase stalls the output long enough to back up the input.
                    if (phase == PressurePhase && n == PressureStart) sink_hold_req = 1'b1;
                    if (phase == PressurePhase && n >= PressureStart && n < PressureEnd) begin
                        gap = 0;
                    end else begin
                        gap = idle_length(source_gap_pct);
                    end
                    send_block(random_half(), random_half(), random_dim(), random_dim(), gap);
                end
                drain_requests();
                phase++;
            end
        end

        if (scoreboard.expected_blocks.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     scoreboard.expected_blocks.size());
            scoreboard.mismatches++;
        end
        $display("Sent %0d blocks across %0d format/transform pairings, spare codes included,",
                 blocks_sent, phase);
        $display("with reduced mip sizes and a %0d-cycle output hold-off; %0d results checked.",
                 SinkHoldCycles, scoreboard.checked);
        if (scoreboard.mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* dxt_block_flip_rotate.f */
+incdir+hdl
hdl/dfr_pkg.sv
hdl/dfr_perm.sv
hdl/dxt_block_flip_rotate.sv
hdl/dfr_checker.sv
test/dxt_block_flip_rotate_test.sv
